// ===== rtl/uac_pkg.sv =====
// Shared types, constants and codes for the UTF-8 affine cipher block.
// Used by uac_modunit, uac_emit and the top level utf8_affine_cipher.
package uac_pkg;

  localparam int CP_W  = 21;
  localparam int CNT_W = $clog2(CP_W + 1);

  typedef logic [CP_W-1:0] cp_t;

  // UTF-8 lead and mask constants
  localparam logic [7:0] LEAD_CONT = 8'h80;
  localparam logic [7:0] LEAD_TWO  = 8'hC0;
  localparam logic [7:0] LEAD_THR  = 8'hE0;
  localparam logic [7:0] LEAD_FOUR = 8'hF0;
  localparam logic [7:0] MASK_TWO  = 8'h1F;
  localparam logic [7:0] MASK_THR  = 8'h0F;
  localparam logic [7:0] MASK_FOUR = 8'h07;
  localparam logic [7:0] MASK_CONT = 8'h3F;
  localparam cp_t        LIM_ONE   = cp_t'(32'h80);
  localparam cp_t        LIM_TWO   = cp_t'(32'h800);
  localparam cp_t        LIM_THR   = cp_t'(32'h10000);

  // Key reset values
  localparam cp_t KEY_MULT_RST = cp_t'(1);
  localparam cp_t KEY_ADD_RST  = cp_t'(0);
  localparam cp_t KEY_MOD_RST  = cp_t'(1114112);
  localparam cp_t KEY_INV_RST  = cp_t'(1);

  typedef enum logic [2:0] {
    REG_DECRYPT_MODE     = 3'd0,
    REG_KEY_MULT         = 3'd1,
    REG_KEY_ADD          = 3'd2,
    REG_KEY_MODULUS      = 3'd3,
    REG_KEY_MULT_INVERSE = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_PREP_GO,
    SEQ_PREP_A,
    SEQ_PREP_B,
    SEQ_PREP_I,
    SEQ_PREP_IB,
    SEQ_MUL,
    SEQ_HAND
  } seq_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       no_data;
    logic       run_last;
    logic       text_done;
  } out_item_t;

  // request to the shared modular multiply unit: (mult * coef) mod m
  typedef struct packed {
    logic start;
    cp_t  mult;
    cp_t  coef;
  } mu_req_t;

  // hand-off of one finished code point to the output stage
  typedef struct packed {
    logic load;
    cp_t  point;
    logic no_data;
    logic text_end;
  } em_req_t;

endpackage

// ===== rtl/uac_modunit.sv =====
// Shared modular multiply unit: (mult * coef) mod m by MSB-first shift-add,
// one coefficient bit per cycle. Depends on uac_pkg.
module uac_modunit import uac_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  mu_req_t req,
  input  cp_t     modulus,
  output logic    done,
  output cp_t     result
);

  cp_t              acc;
  cp_t              mult;
  cp_t              coef;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [CP_W+1:0]  t;
  logic [CP_W+1:0]  m1;
  logic [CP_W+1:0]  m2;
  logic [CP_W+1:0]  r;

  assign m1 = {2'b00, modulus};
  assign m2 = {1'b0, modulus, 1'b0};

  // acc < m and mult < m, so t < 3m: pick t, t-m or t-2m
  always_comb begin
    t = {1'b0, acc, 1'b0} + (coef[CP_W-1] ? {2'b00, mult} : '0);
    if (t >= m2) begin
      r = t - m2;
    end else if (t >= m1) begin
      r = t - m1;
    end else begin
      r = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(CP_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc  <= '0;
      mult <= req.mult;
      coef <= req.coef;
    end else if (busy) begin
      acc  <= r[CP_W-1:0];
      coef <= {coef[CP_W-2:0], 1'b0};
    end
  end

  assign result = acc;

endmodule

// ===== rtl/uac_emit.sv =====
// Output stage: encodes one code point as UTF-8 and shifts its bytes out,
// one beat per byte. Depends on uac_pkg.
module uac_emit import uac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  em_req_t   req,
  output logic      ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [31:0] sh;
  logic [1:0]  rem;
  logic        nodata;
  logic        last_end;
  logic [31:0] enc;
  logic [1:0]  enc_rem;
  cp_t         cp;

  always_comb begin
    cp = req.point;
    if (cp < LIM_ONE) begin
      enc     = {cp[7:0], 24'h0};
      enc_rem = 2'd0;
    end else if (cp < LIM_TWO) begin
      enc     = {LEAD_TWO | {3'b000, cp[10:6]}, LEAD_CONT | {2'b00, cp[5:0]}, 16'h0};
      enc_rem = 2'd1;
    end else if (cp < LIM_THR) begin
      enc     = {LEAD_THR | {4'h0, cp[15:12]}, LEAD_CONT | {2'b00, cp[11:6]},
                 LEAD_CONT | {2'b00, cp[5:0]}, 8'h0};
      enc_rem = 2'd2;
    end else begin
      enc     = {LEAD_FOUR | {5'h00, cp[20:18]}, LEAD_CONT | {2'b00, cp[17:12]},
                 LEAD_CONT | {2'b00, cp[11:6]}, LEAD_CONT | {2'b00, cp[5:0]}};
      enc_rem = 2'd3;
    end
  end

  assign ready = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall && rem == 2'd0) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.load) begin
      sh       <= enc;
      rem      <= enc_rem;
      nodata   <= req.no_data;
      last_end <= req.text_end;
    end else if (out_valid && !out_stall && rem != 2'd0) begin
      // advance to the next byte of the sequence
      sh  <= {sh[23:0], 8'h0};
      rem <= rem - 1'b1;
    end
  end

  assign out_data.out_byte  = sh[31:24];
  assign out_data.no_data   = nodata;
  assign out_data.run_last  = (rem == 2'd0);
  assign out_data.text_done = (rem == 2'd0) && last_end;

endmodule

// ===== rtl/utf8_affine_cipher.sv =====
// UTF-8 affine cipher block.
// Input channel (in_valid/in_stall/in_data) takes one text byte per beat.
// Bytes are decoded leniently into code points; each code point x becomes
// (a*x+b) mod m when encrypting or inv*(x-b) mod m when decrypting, and is
// sent as 1 to 4 UTF-8 bytes on the output channel (out_valid/out_stall/
// out_data), one byte per beat, run_last on the last byte of a code point.
// A text_end byte that completes no code point gives one no_data beat.
// Bytes that finish no code point leave the input free for the next byte. A
// finished code point goes through 21 steps of the shared modular multiply
// unit (one code point bit per step), the final add or subtract and the
// hand-off; the first byte leaves in the cycle after the hand-off. With
// modulus 0 the point goes straight to the hand-off.
// A configuration write (cfg_valid/cfg_ready, always ready) starts key
// reduction: four passes of the multiply unit (none with modulus 0), with
// in_stall high. Reset loads the default keys already reduced, no set-up.
// A stalled output holds its byte; the next input byte is still taken and
// processed until its code point needs the output stage.
module utf8_affine_cipher import uac_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  cp_t        cfg_data
);

  seq_state_t state, state_next;

  // configuration
  logic decrypt_mode;
  cp_t  key_mult, key_add, key_modulus, key_mult_inverse;
  // keys reduced mod m, and inv*b mod m
  cp_t  red_mult, red_add, red_inv, inv_add;

  // decoder state
  cp_t        partial_point, partial_point_next;
  logic [1:0] bytes_pending, bytes_pending_next;
  logic       have;
  cp_t        cp;

  // item being transformed
  cp_t  hand_point;
  logic hand_nodata;
  logic hand_end;

  logic    accept;
  logic    cfg_write;
  logic    mod_zero;
  cp_t     one_mod;
  mu_req_t mu_req;
  logic    mu_done;
  cp_t     mu_result;
  em_req_t em_req;
  logic    em_ready;
  cp_t     fixed;
  logic [CP_W:0] fsum;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid;
  assign mod_zero  = (key_modulus == '0);
  assign one_mod   = cp_t'(key_modulus != cp_t'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode     <= 1'b0;
      key_mult         <= KEY_MULT_RST;
      key_add          <= KEY_ADD_RST;
      key_modulus      <= KEY_MOD_RST;
      key_mult_inverse <= KEY_INV_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DECRYPT_MODE:     decrypt_mode     <= cfg_data[0];
        REG_KEY_MULT:         key_mult         <= cfg_data;
        REG_KEY_ADD:          key_add          <= cfg_data;
        REG_KEY_MODULUS:      key_modulus      <= cfg_data;
        REG_KEY_MULT_INVERSE: key_mult_inverse <= cfg_data;
        default: ;
      endcase
    end
  end

  // lenient UTF-8 decode of the incoming byte
  always_comb begin
    logic [7:0] b;
    b                  = in_data.in_byte;
    have               = 1'b0;
    cp                 = '0;
    partial_point_next = partial_point;
    bytes_pending_next = bytes_pending;
    if (bytes_pending == 2'd0) begin
      if (b < LEAD_CONT) begin
        cp   = cp_t'(b);
        have = 1'b1;
      end else if (b < LEAD_TWO) begin
        // stray continuation: drop
      end else if (b < LEAD_THR) begin
        partial_point_next = cp_t'(b & MASK_TWO);
        bytes_pending_next = 2'd1;
      end else if (b < LEAD_FOUR) begin
        partial_point_next = cp_t'(b & MASK_THR);
        bytes_pending_next = 2'd2;
      end else begin
        partial_point_next = cp_t'(b & MASK_FOUR);
        bytes_pending_next = 2'd3;
      end
    end else begin
      partial_point_next = {partial_point[CP_W-7:0], b[5:0]};
      bytes_pending_next = bytes_pending - 1'b1;
      if (bytes_pending_next == 2'd0) begin
        cp   = partial_point_next;
        have = 1'b1;
      end
    end
    // text cut short: flush what was gathered
    if (!have && in_data.text_end && bytes_pending_next != 2'd0) begin
      cp   = partial_point_next;
      have = 1'b1;
    end
    if (have) begin
      partial_point_next = '0;
    end
    if (in_data.text_end) begin
      partial_point_next = '0;
      bytes_pending_next = 2'd0;
    end
  end

  // final add of b (encrypt) or subtract of inv*b (decrypt), mod m
  always_comb begin
    fsum  = '0;
    fixed = mu_result;
    if (!decrypt_mode) begin
      fsum = {1'b0, mu_result} + {1'b0, red_add};
      if (fsum >= {1'b0, key_modulus}) begin
        fsum = fsum - {1'b0, key_modulus};
      end
      fixed = fsum[CP_W-1:0];
    end else if (mu_result >= inv_add) begin
      fixed = mu_result - inv_add;
    end else begin
      fsum  = {1'b0, mu_result} + {1'b0, key_modulus} - {1'b0, inv_add};
      fixed = fsum[CP_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (accept && (have || in_data.text_end)) begin
          state_next = (have && !mod_zero) ? SEQ_MUL : SEQ_HAND;
        end
      end
      SEQ_PREP_GO: state_next = mod_zero ? SEQ_IDLE : SEQ_PREP_A;
      SEQ_PREP_A:  if (mu_done) state_next = SEQ_PREP_B;
      SEQ_PREP_B:  if (mu_done) state_next = SEQ_PREP_I;
      SEQ_PREP_I:  if (mu_done) state_next = SEQ_PREP_IB;
      SEQ_PREP_IB: if (mu_done) state_next = SEQ_IDLE;
      SEQ_MUL:     if (mu_done) state_next = SEQ_HAND;
      SEQ_HAND:    if (em_ready) state_next = SEQ_IDLE;
      default:     state_next = SEQ_IDLE;
    endcase
    // key change: redo the reductions
    if (cfg_write) begin
      state_next = SEQ_PREP_GO;
    end
  end

  // outputs of the sequencer
  always_comb begin
    in_stall       = (state != SEQ_IDLE);
    accept         = in_valid && (state == SEQ_IDLE);
    mu_req         = '0;
    em_req.load    = 1'b0;
    em_req.point   = hand_point;
    em_req.no_data = hand_nodata;
    em_req.text_end = hand_end;
    unique case (state)
      SEQ_IDLE: begin
        if (accept && have && !mod_zero) begin
          mu_req.start = 1'b1;
          mu_req.mult  = decrypt_mode ? red_inv : red_mult;
          mu_req.coef  = cp;
        end
      end
      SEQ_PREP_GO: begin
        mu_req.start = !mod_zero;
        mu_req.mult  = one_mod;
        mu_req.coef  = key_mult;
      end
      SEQ_PREP_A: begin
        mu_req.start = mu_done;
        mu_req.mult  = one_mod;
        mu_req.coef  = key_add;
      end
      SEQ_PREP_B: begin
        mu_req.start = mu_done;
        mu_req.mult  = one_mod;
        mu_req.coef  = key_mult_inverse;
      end
      SEQ_PREP_I: begin
        mu_req.start = mu_done;
        mu_req.mult  = mu_result;
        mu_req.coef  = red_add;
      end
      SEQ_HAND: em_req.load = em_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= SEQ_IDLE;
      partial_point <= '0;
      bytes_pending <= '0;
      red_mult      <= KEY_MULT_RST;
      red_add       <= KEY_ADD_RST;
      red_inv       <= KEY_INV_RST;
      inv_add       <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        partial_point <= partial_point_next;
        bytes_pending <= bytes_pending_next;
      end
      if (mu_done) begin
        unique case (state)
          SEQ_PREP_A:  red_mult <= mu_result;
          SEQ_PREP_B:  red_add  <= mu_result;
          SEQ_PREP_I:  red_inv  <= mu_result;
          SEQ_PREP_IB: inv_add  <= mu_result;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hand_point  <= have ? cp : '0;
      hand_nodata <= !have;
      hand_end    <= in_data.text_end;
    end else if (state == SEQ_MUL && mu_done) begin
      hand_point <= fixed;
    end
  end

  uac_modunit u_modunit (
    .clk     (clk),
    .rst     (rst),
    .req     (mu_req),
    .modulus (key_modulus),
    .done    (mu_done),
    .result  (mu_result)
  );

  uac_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .req       (em_req),
    .ready     (em_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
